FILE: rtl/uvdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvdq_pkg
// Shared sizes, request kinds and status codes for the unique value deque.
// ----------------------------------------------------------------------------
package uvdq_pkg;

   localparam int DEPTH  = 16;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH + 1);

   localparam int KIND_W = 4;
   localparam int VAL_W  = 32;
   localparam int IDX_W  = 8;
   localparam int ST_W   = 3;
   localparam int CNT_W  = 9;

   typedef logic signed [VAL_W-1:0] value_type;

   localparam logic [KIND_W-1:0] KIND_INS_HEAD  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_INS_TAIL  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_RM_HEAD   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_RM_TAIL   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_RM_VALUE  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_CONTAINS  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_READ_AT   = 4'd6;
   localparam logic [KIND_W-1:0] KIND_PEEK_HEAD = 4'd7;
   localparam logic [KIND_W-1:0] KIND_PEEK_TAIL = 4'd8;

   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
   localparam logic [ST_W-1:0] ST_DUP   = 3'd4;
   localparam logic [ST_W-1:0] ST_MISS  = 3'd5;

endpackage

FILE: rtl/uvdq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvdq_if
// Request and response channels of the unique value deque.
// ----------------------------------------------------------------------------
interface uvdq_req_if import uvdq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   value_type         value;
   logic [IDX_W-1:0]  index;

   modport source (output valid, output kind, output value, output index, input ready);
   modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface uvdq_rsp_if import uvdq_pkg::*; ();
   logic             valid;
   logic             ready;
   value_type        result_value;
   logic             hit;
   logic [ST_W-1:0]  status;
   logic [CNT_W-1:0] entry_count;

   modport source (output valid, output result_value, output hit, output status,
                   output entry_count, input ready);
   modport sink   (input valid, input result_value, input hit, input status,
                   input entry_count, output ready);
endinterface

FILE: rtl/uvdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uvdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/unique_value_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_deque_core
// Ordered store of distinct values; one entry per cycle through one RAM.
// ----------------------------------------------------------------------------
// Empty ends, bad indexes and unused kinds go straight to the response; peek,
// read at and remove tail read one entry; contains and insert tail search the
// entries; remove value and remove head then shift the later entries down, and
// insert head searches and then shifts every entry up before writing slot 0.
// One request at a time; the RAM's single read port and single write port set the pace.
// Reset (synchronous) empties the store; entries are not cleared.
// ----------------------------------------------------------------------------
module unique_value_deque_core import uvdq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   uvdq_req_if.sink   req_ch,
   uvdq_rsp_if.source rsp_ch
);

   localparam int CMP_W = (IDX_W > CW) ? IDX_W : CW;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_CAPT   = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]        state_ff,   state_in;
   logic [CW-1:0]     count_ff,   count_in;
   logic              mv_vld_ff,  mv_vld_in;
   logic              chk_vld_ff, chk_vld_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic [KIND_W-1:0] kind_ff,    kind_in;
   value_type         value_ff,   value_in;
   logic [AW-1:0]     src_ff,     src_in;
   logic [AW-1:0]     dst_ff,     dst_in;
   logic [CW-1:0]     left_ff,    left_in;
   logic              dir_ff,     dir_in;
   logic [AW-1:0]     chk_idx_ff, chk_idx_in;
   value_type         res_ff,     res_in;
   logic              hit_ff,     hit_in;
   logic [ST_W-1:0]   st_ff,      st_in;
   value_type         rsp_val_ff, rsp_val_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [ST_W-1:0]   rsp_st_ff,  rsp_st_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [VAL_W-1:0]  rd_data;
   logic              req_xfer;
   logic              is_empty;
   logic              is_full;

   uvdq_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && (state_ff == S_IDLE);
   assign is_empty     = (count_ff == '0);
   assign is_full      = (count_ff >= CW'(DEPTH));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      mv_vld_in  = mv_vld_ff;
      chk_vld_in = chk_vld_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      left_in    = left_ff;
      dir_in     = dir_ff;
      chk_idx_in = chk_idx_ff;
      res_in     = res_ff;
      hit_in     = hit_ff;
      st_in      = st_ff;
      rsp_val_in = rsp_val_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_st_in  = rsp_st_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      wr_en      = 1'b0;
      wr_addr    = dst_ff;
      wr_data    = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               kind_in    = req_ch.kind;
               value_in   = req_ch.value;
               res_in     = '0;
               hit_in     = 1'b0;
               st_in      = ST_OK;
               chk_vld_in = 1'b0;
               mv_vld_in  = 1'b0;
               case (req_ch.kind)
                  KIND_INS_HEAD, KIND_INS_TAIL, KIND_RM_VALUE, KIND_CONTAINS: begin
                     src_in   = '0;
                     left_in  = count_ff;
                     state_in = S_SEARCH;
                  end
                  KIND_RM_HEAD, KIND_PEEK_HEAD: begin
                     if (is_empty) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        src_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  KIND_RM_TAIL, KIND_PEEK_TAIL: begin
                     if (is_empty) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        src_in   = AW'(count_ff - CW'(1));
                        state_in = S_READ;
                     end
                  end
                  KIND_READ_AT: begin
                     if (CMP_W'(req_ch.index) >= CMP_W'(count_ff)) begin
                        st_in    = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        src_in   = req_ch.index[AW-1:0];
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_CAPT;
         end

         S_CAPT: begin
            res_in = rd_data;
            hit_in = 1'b1;
            case (kind_ff)
               KIND_RM_HEAD: begin
                  src_in    = AW'(1);
                  left_in   = count_ff - CW'(1);
                  dir_in    = 1'b0;
                  mv_vld_in = 1'b0;
                  state_in  = S_SHIFT;
               end
               KIND_RM_TAIL: begin
                  count_in = count_ff - CW'(1);
                  state_in = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_SEARCH: begin
            if (chk_vld_ff && (rd_data == value_ff)) begin
               // match at chk_idx_ff
               chk_vld_in = 1'b0;
               case (kind_ff)
                  KIND_RM_VALUE: begin
                     res_in    = value_ff;
                     hit_in    = 1'b1;
                     src_in    = chk_idx_ff + AW'(1);
                     left_in   = count_ff - CW'(1) - CW'(chk_idx_ff);
                     dir_in    = 1'b0;
                     mv_vld_in = 1'b0;
                     state_in  = S_SHIFT;
                  end
                  KIND_CONTAINS: begin
                     hit_in   = 1'b1;
                     state_in = S_RESP;
                  end
                  default: begin
                     st_in    = ST_DUP;
                     state_in = S_RESP;
                  end
               endcase
            end else if (left_ff != '0) begin
               chk_vld_in = 1'b1;
               chk_idx_in = src_ff;
               src_in     = src_ff + AW'(1);
               left_in    = left_ff - CW'(1);
            end else if (chk_vld_ff) begin
               chk_vld_in = 1'b0;
            end else begin
               // value not stored
               case (kind_ff)
                  KIND_RM_VALUE: begin
                     st_in    = ST_MISS;
                     state_in = S_RESP;
                  end
                  KIND_CONTAINS: begin
                     state_in = S_RESP;
                  end
                  default: begin
                     if (is_full) begin
                        st_in    = ST_FULL;
                        state_in = S_RESP;
                     end else if (kind_ff == KIND_INS_TAIL) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = value_ff;
                        count_in = count_ff + CW'(1);
                        hit_in   = 1'b1;
                        state_in = S_RESP;
                     end else begin
                        src_in    = AW'(count_ff - CW'(1));
                        left_in   = count_ff;
                        dir_in    = 1'b1;
                        mv_vld_in = 1'b0;
                        hit_in    = 1'b1;
                        state_in  = S_SHIFT;
                     end
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // read src, write previous read one slot over
            if (mv_vld_ff) begin
               wr_en = 1'b1;
            end
            if (left_ff != '0) begin
               mv_vld_in = 1'b1;
               left_in   = left_ff - CW'(1);
               if (dir_ff) begin
                  dst_in = src_ff + AW'(1);
                  src_in = src_ff - AW'(1);
               end else begin
                  dst_in = src_ff - AW'(1);
                  src_in = src_ff + AW'(1);
               end
            end else begin
               mv_vld_in = 1'b0;
               if (!mv_vld_ff) begin
                  if (dir_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = value_ff;
                     count_in = count_ff + CW'(1);
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
                  state_in = S_RESP;
               end
            end
         end

         S_RESP: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in = 1'b1;
               rsp_val_in = res_ff;
               rsp_hit_in = hit_ff;
               rsp_st_in  = st_ff;
               rsp_cnt_in = CNT_W'(count_ff);
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         mv_vld_ff  <= 1'b0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         mv_vld_ff  <= mv_vld_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      left_ff    <= left_in;
      dir_ff     <= dir_in;
      chk_idx_ff <= chk_idx_in;
      res_ff     <= res_in;
      hit_ff     <= hit_in;
      st_ff      <= st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.result_value = rsp_val_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.status       = rsp_st_ff;
   assign rsp_ch.entry_count  = rsp_cnt_ff;

endmodule

FILE: bench/uvdq_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvdq_tb_pkg
// Tracking model of the unique value deque: keeps its own copy of the stored
// values, works out the response to every accepted request and checks each
// response transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package uvdq_tb_pkg;
   import uvdq_pkg::*;

   typedef struct packed {
      value_type        result_value;
      logic             hit;
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] entry_count;
   } deque_outcome_type;

   class uvdq_tracker;
      value_type         contents[DEPTH];
      int unsigned       stored;
      deque_outcome_type outstanding[$];
      int unsigned       mismatches;

      function new();
         stored     = 0;
         mismatches = 0;
      endfunction

      function int locate(value_type v);
         for (int i = 0; i < stored; i++) begin
            if (contents[i] == v) return i;
         end
         return -1;
      endfunction

      function value_type take_at(int unsigned pos);
         value_type v;
         v = contents[pos];
         for (int unsigned i = pos; i + 1 < stored; i++) contents[i] = contents[i + 1];
         stored--;
         return v;
      endfunction

      function value_type pick_member();
         return contents[$urandom_range(0, stored - 1)];
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, value_type value,
                                 logic [IDX_W-1:0] index);
         deque_outcome_type o;
         int pos;
         o        = '0;
         o.status = ST_OK;
         case (kind)
            KIND_INS_HEAD, KIND_INS_TAIL: begin
               if (locate(value) >= 0) begin
                  o.status = ST_DUP;
               end else if (stored >= DEPTH) begin
                  o.status = ST_FULL;
               end else begin
                  if (kind == KIND_INS_HEAD) begin
                     for (int unsigned i = stored; i > 0; i--) contents[i] = contents[i - 1];
                     contents[0] = value;
                  end else begin
                     contents[stored] = value;
                  end
                  stored++;
                  o.hit = 1'b1;
               end
            end
            KIND_RM_HEAD, KIND_RM_TAIL: begin
               if (stored == 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  o.result_value = take_at(kind == KIND_RM_HEAD ? 0 : stored - 1);
                  o.hit          = 1'b1;
               end
            end
            KIND_RM_VALUE: begin
               pos = locate(value);
               if (pos < 0) begin
                  o.status = ST_MISS;
               end else begin
                  o.result_value = take_at(pos);
                  o.hit          = 1'b1;
               end
            end
            KIND_CONTAINS: begin
               o.hit = (locate(value) >= 0);
            end
            KIND_READ_AT: begin
               if (index >= stored) begin
                  o.status = ST_RANGE;
               end else begin
                  o.result_value = contents[index];
                  o.hit          = 1'b1;
               end
            end
            KIND_PEEK_HEAD, KIND_PEEK_TAIL: begin
               if (stored == 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  o.result_value = contents[kind == KIND_PEEK_HEAD ? 0 : stored - 1];
                  o.hit          = 1'b1;
               end
            end
            default: begin
            end
         endcase
         o.entry_count = CNT_W'(stored);
         outstanding.push_back(o);
      endfunction

      function void check_response(value_type rv, logic hit, logic [ST_W-1:0] st,
                                   logic [CNT_W-1:0] cnt);
         deque_outcome_type e;
         if (outstanding.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"response transfer with nothing outstanding: ",
                         "value %0d hit %0d status %0d count %0d"},
                        rv, hit, st, cnt);
            return;
         end
         e = outstanding.pop_front();
         if (rv !== e.result_value || hit !== e.hit || st !== e.status ||
             cnt !== e.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected value %0d hit %0d status %0d count %0d, ",
                         "got value %0d hit %0d status %0d count %0d"},
                        e.result_value, e.hit, e.status, e.entry_count,
                        rv, hit, st, cnt);
         end
      endfunction
   endclass

endpackage

FILE: bench/unique_value_deque_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_deque_core_test
// Drives directed corner requests and then random grow, shrink and mixed runs
// into the deque, with random gaps on the request side and random stalls on
// the response side, and checks every response transfer in order.
// ----------------------------------------------------------------------------
module unique_value_deque_core_test;
   import uvdq_pkg::*;
   import uvdq_tb_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 550;
   localparam logic [KIND_W-1:0] KIND_LAST = {KIND_W{1'b1}};

   logic clock = 1'b0;
   logic reset;
   bit   quiet;

   uvdq_req_if req_ch();
   uvdq_rsp_if rsp_ch();

   uvdq_tracker sb;

   unique_value_deque_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic value_type pool_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0;
         3: return -32'sd1;
         default: return $urandom_range(0, 11) - 6;
      endcase
   endfunction

   function automatic value_type pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4 && sb.stored > 0) return sb.pick_member();
      if (r < 7) return pool_value();
      return $urandom;
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(int unsigned mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3) return KIND_W'($urandom_range(KIND_PEEK_TAIL + 1, KIND_LAST));
      case (mode)
         0: begin
            if (r < 35) return KIND_INS_HEAD;
            if (r < 65) return KIND_INS_TAIL;
         end
         1: begin
            if (r < 20) return KIND_RM_HEAD;
            if (r < 40) return KIND_RM_TAIL;
            if (r < 65) return KIND_RM_VALUE;
         end
         default: begin
         end
      endcase
      return KIND_W'($urandom_range(KIND_INS_HEAD, KIND_PEEK_TAIL));
   endfunction

   task automatic send_request(input logic [KIND_W-1:0] kind, input value_type value,
                               input logic [IDX_W-1:0] index);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.value <= value;
      req_ch.index <= index;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(kind, value, index);
   endtask

   // response side: random stalls
   initial begin
      int unsigned stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.result_value, rsp_ch.hit, rsp_ch.status,
                           rsp_ch.entry_count);
   end

   initial begin
      #2_000_000;
      $display("unique_value_deque_core test failed");
      $finish;
   end

   initial begin
      int unsigned done;
      int unsigned mode;
      int unsigned run_len;
      logic [KIND_W-1:0] kind;
      value_type value;
      logic [IDX_W-1:0] index;

      sb = new();
      quiet = 1'b0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_INS_HEAD;
      req_ch.value <= '0;
      req_ch.index <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corners on an empty store
      send_request(KIND_PEEK_HEAD, 32'sd0, 8'd0);
      send_request(KIND_PEEK_TAIL, 32'sd0, 8'd0);
      send_request(KIND_RM_HEAD, 32'sd0, 8'd0);
      send_request(KIND_RM_TAIL, 32'sd0, 8'd0);
      send_request(KIND_RM_VALUE, 32'sd0, 8'd0);
      send_request(KIND_READ_AT, 32'sd0, 8'd0);
      send_request(KIND_CONTAINS, 32'sd0, 8'd0);
      // extremes, duplicates, reads around the tail
      send_request(KIND_INS_HEAD, 32'sh8000_0000, 8'd0);
      send_request(KIND_INS_TAIL, 32'sh7fff_ffff, 8'd0);
      send_request(KIND_INS_HEAD, 32'sd0, 8'd0);
      send_request(KIND_INS_TAIL, -32'sd1, 8'hff);
      send_request(KIND_INS_TAIL, 32'sh8000_0000, 8'd0);
      send_request(KIND_CONTAINS, 32'sh7fff_ffff, 8'd0);
      send_request(KIND_READ_AT, 32'sd0, 8'd3);
      send_request(KIND_READ_AT, 32'sd0, 8'd4);
      send_request(KIND_READ_AT, 32'sd0, 8'hff);
      send_request(KIND_PEEK_HEAD, 32'sd0, 8'd0);
      send_request(KIND_PEEK_TAIL, 32'sd0, 8'd0);
      send_request(KIND_RM_VALUE, 32'sh8000_0000, 8'd0);
      send_request(KIND_W'(KIND_PEEK_TAIL + 1), 32'sd5, 8'd1);
      send_request(KIND_LAST, -32'sd1, 8'hff);
      send_request(KIND_RM_HEAD, 32'sd0, 8'd0);
      send_request(KIND_RM_TAIL, 32'sd0, 8'd0);
      send_request(KIND_CONTAINS, 32'sd5, 8'd0);

      // random runs: 0 grow, 1 shrink, 2 mixed
      done = 0;
      while (done < RANDOM_ITEMS) begin
         mode    = $urandom_range(0, 2);
         run_len = $urandom_range(8, 40);
         quiet   = ($urandom_range(0, 4) == 0);
         for (int unsigned n = 0; n < run_len && done < RANDOM_ITEMS; n++) begin
            kind  = pick_kind(mode);
            value = pick_value();
            if (kind == KIND_READ_AT && $urandom_range(0, 9) < 7)
               index = IDX_W'($urandom_range(0, sb.stored + 1));
            else
               index = IDX_W'($urandom_range(0, 255));
            send_request(kind, value, index);
            if (kind <= KIND_PEEK_TAIL) done++;
         end
      end
      req_ch.valid <= 1'b0;
      quiet = 1'b0;

      while (sb.outstanding.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding.size() == 0) begin
         $display("unique_value_deque_core test passed");
      end else begin
         $display("unique_value_deque_core test failed");
      end
      $finish;
   end

endmodule

FILE: unique_value_deque_core.f
rtl/uvdq_pkg.sv
rtl/uvdq_if.sv
rtl/uvdq_ram.sv
rtl/unique_value_deque_core.sv
bench/uvdq_tb_pkg.sv
bench/unique_value_deque_core_test.sv
